### rtl/vofd_pkg.sv
package vofd_pkg;

  // block dimensions
  localparam int CHANNELS = 4;
  localparam int HISTORY  = 256;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIST_W = $clog2(HISTORY);
  localparam int LEN_W  = $clog2(HISTORY + 1);

  // field widths
  localparam int SAMPLE_W = 32;
  localparam int ORDER_W  = 16;
  localparam int PERIOD_W = 24;
  localparam int HLEN_W   = 9;
  localparam int CFG_W    = 32;
  localparam int IN_W     = CHANNELS * (SAMPLE_W + ORDER_W);
  localparam int OUT_W    = CHANNELS * SAMPLE_W;

  // configuration register indexes
  localparam int CFG_IDX_W       = $clog2(2 + CHANNELS);
  localparam int REG_LOG2_PERIOD = 0;
  localparam int REG_HIST_LEN    = 1;
  localparam int REG_INIT_BASE   = 2;

  // weight recursion numerator and divider sizing
  localparam int NUM_W     = $clog2(HISTORY * 4096 + 32768) + 1;
  localparam int DIVD_W    = NUM_W + 18;
  localparam int DIV_DIGIT = 4;
  localparam int DIV_STEPS = (DIVD_W + DIV_DIGIT - 1) / DIV_DIGIT;
  localparam int DIVP_W    = DIV_STEPS * DIV_DIGIT;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // accumulator width: scaled sample plus one product term per history step
  localparam int ACC_W = 50 + HIST_W;

  localparam logic signed [47:0] DMAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] DMAX64 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [31:0] W_ONE  = 32'sh0010_0000;

  // integer square root, used only at elaboration
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] t;
    v = x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      t = r + b;
      if (v >= t) begin
        v = v - t;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q30
  function automatic logic [31:0] exp_rom_val(input int k);
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    for (int i = 2; i <= k; i++) begin
      r = isqrt64({r[33:0], 30'd0});
    end
    return r[31:0];
  endfunction

  localparam logic [31:0] EXP_ROM [16] = '{
    exp_rom_val(1),  exp_rom_val(2),  exp_rom_val(3),  exp_rom_val(4),
    exp_rom_val(5),  exp_rom_val(6),  exp_rom_val(7),  exp_rom_val(8),
    exp_rom_val(9),  exp_rom_val(10), exp_rom_val(11), exp_rom_val(12),
    exp_rom_val(13), exp_rom_val(14), exp_rom_val(15), exp_rom_val(16)
  };

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [HIST_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVP_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/vofd_ram.sv
module vofd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/vofd_mul.sv
module vofd_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod_r
);

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

### rtl/vofd_div.sv
module vofd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  vofd_pkg::div_req_t req,
  output vofd_pkg::div_rsp_t rsp
);

  logic                               busy_r;
  logic                               done_r;
  logic [vofd_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [vofd_pkg::DIVP_W-1:0]        dvd_r;
  logic [vofd_pkg::DIVP_W-1:0]        quot_r;
  logic [vofd_pkg::HIST_W-1:0]        dsr_r;
  logic [vofd_pkg::HIST_W-1:0]        rem_r;
  logic [vofd_pkg::DIVP_W-1:0]        dvd_nxt;
  logic [vofd_pkg::DIVP_W-1:0]        quot_nxt;
  logic [vofd_pkg::HIST_W-1:0]        rem_nxt;

  // restoring division, one digit of DIV_DIGIT bits per cycle
  always_comb begin
    logic [vofd_pkg::HIST_W:0] r2;
    logic [vofd_pkg::HIST_W-1:0] r;
    logic [vofd_pkg::DIVP_W-1:0] d;
    logic [vofd_pkg::DIVP_W-1:0] q;
    r = rem_r;
    d = dvd_r;
    q = quot_r;
    for (int i = 0; i < vofd_pkg::DIV_DIGIT; i++) begin
      r2 = {r, d[vofd_pkg::DIVP_W-1]};
      d  = {d[vofd_pkg::DIVP_W-2:0], 1'b0};
      if (r2 >= {1'b0, dsr_r}) begin
        r2 = r2 - {1'b0, dsr_r};
        q  = {q[vofd_pkg::DIVP_W-2:0], 1'b1};
      end else begin
        q  = {q[vofd_pkg::DIVP_W-2:0], 1'b0};
      end
      r = r2[vofd_pkg::HIST_W-1:0];
    end
    rem_nxt  = r;
    dvd_nxt  = d;
    quot_nxt = q;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= vofd_pkg::DIV_CNT_W'(vofd_pkg::DIV_STEPS - 1);
        dvd_r  <= vofd_pkg::DIVP_W'(req.dividend);
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        quot_r <= '0;
      end else if (busy_r) begin
        dvd_r  <= dvd_nxt;
        rem_r  <= rem_nxt;
        quot_r <= quot_nxt;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

### rtl/variable_order_fractional_difference.sv
// channel | direction | beat contents
// in_     | slave     | samples and orders of all channels for one time step
// out_    | master    | new values of all channels for that step
// cfg_    | write     | period, history length, initial values
//
// a step's run time is set by the shared 32x32 multiplier and the 4-bit-per-cycle
// weight divider, walked once per history step per channel. after reset and after
// every initial value write, a fill pass loads the history, with in_tready low.
// a finished beat waits in the output register while the next step runs; a step
// that ends before that beat is taken holds until it is.
module variable_order_fractional_difference (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // sample_0..sample_3 (32 bit each), then order_0..order_3 (16 bit each)
  input  logic [vofd_pkg::IN_W-1:0]           in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_0..out_3, 32 bit each
  output logic [vofd_pkg::OUT_W-1:0]          out_tdata,
  input  logic                                cfg_we,
  input  logic [vofd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vofd_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EXPM = 4'd1;
  localparam logic [3:0] ST_EXPE = 4'd2;
  localparam logic [3:0] ST_MISS = 4'd3;
  localparam logic [3:0] ST_MTAK = 4'd4;
  localparam logic [3:0] ST_SMUL = 4'd5;
  localparam logic [3:0] ST_SCAL = 4'd6;
  localparam logic [3:0] ST_WMUL = 4'd7;
  localparam logic [3:0] ST_WLD  = 4'd8;
  localparam logic [3:0] ST_WDIV = 4'd9;
  localparam logic [3:0] ST_TXM  = 4'd10;
  localparam logic [3:0] ST_T0M  = 4'd11;
  localparam logic [3:0] ST_ACC  = 4'd12;
  localparam logic [3:0] ST_RES  = 4'd13;
  localparam logic [3:0] ST_DONE = 4'd14;

  localparam int SW = vofd_pkg::SAMPLE_W;
  localparam int OW = vofd_pkg::ORDER_W;
  localparam int AW = vofd_pkg::ACC_W;
  localparam int HW = vofd_pkg::HIST_W;
  localparam int LW = vofd_pkg::LEN_W;

  logic [3:0]                    state_r;
  logic signed [vofd_pkg::PERIOD_W-1:0] period_r;
  logic [vofd_pkg::HLEN_W-1:0]   hlen_r;
  logic signed [SW-1:0]          init_r [vofd_pkg::CHANNELS];
  logic [vofd_pkg::IN_W-1:0]     item_r;
  logic [HW-1:0]                 pos_r;
  logic [HW-1:0]                 idx_r;
  logic [HW-1:0]                 j_r;
  logic [vofd_pkg::CH_W-1:0]     ch_r;
  logic [15:0]                   f_r;
  logic [3:0]                    k_r;
  logic [31:0]                   m_r;
  logic signed [13:0]            sh_r;
  logic signed [AW-1:0]          d_r;
  logic signed [AW-1:0]          cor_r;
  logic signed [31:0]            w_r;
  logic                          neg_r;
  logic [vofd_pkg::OUT_W-1:0]    res_r;
  logic [vofd_pkg::OUT_W-1:0]    out_tdata_r;
  logic                          out_tvalid_r;
  logic [vofd_pkg::CHANNELS-1:0] fill_pend_r;
  logic [HW-1:0]                 fill_cnt_r;

  logic                          fill_act;
  logic [vofd_pkg::CHANNELS-1:0] init_sel;
  logic [LW-1:0]                 len;
  logic signed [SW-1:0]          samp;
  logic signed [OW-1:0]          ord;
  logic signed [SW-1:0]          x0;
  logic signed [SW-1:0]          hist_rd;
  logic [SW-1:0]                 ram_rd [vofd_pkg::CHANNELS];
  logic signed [vofd_pkg::NUM_W-1:0] num;
  logic signed [31:0]            mul_a;
  logic signed [31:0]            mul_b;
  logic signed [63:0]            prod_r;
  logic signed [AW-1:0]          tsh;
  logic signed [47:0]            dval;
  logic signed [SW-1:0]          res_val;
  logic signed [63:0]            pabs;
  logic signed [31:0]            w_div;
  vofd_pkg::div_req_t            div_req;
  vofd_pkg::div_rsp_t            div_rsp;

  assign fill_act = |fill_pend_r;

  // initial value register decode
  always_comb begin
    init_sel = '0;
    for (int c = 0; c < vofd_pkg::CHANNELS; c++) begin
      init_sel[c] = cfg_we
                    && (cfg_index == vofd_pkg::CFG_IDX_W'(vofd_pkg::REG_INIT_BASE + c));
    end
  end

  // effective history length
  always_comb begin
    if (hlen_r < vofd_pkg::HLEN_W'(2)) begin
      len = LW'(2);
    end else if (int'(hlen_r) > vofd_pkg::HISTORY) begin
      len = LW'(vofd_pkg::HISTORY);
    end else begin
      len = LW'(hlen_r);
    end
  end

  // fields of the current channel
  assign samp    = $signed(item_r[ch_r*SW +: SW]);
  assign ord     = $signed(item_r[vofd_pkg::CHANNELS*SW + ch_r*OW +: OW]);
  assign x0      = init_r[ch_r];
  assign hist_rd = $signed(ram_rd[ch_r]);

  // weight numerator: -order - (j-1)*2^12
  assign num = -vofd_pkg::NUM_W'(ord)
               - $signed(vofd_pkg::NUM_W'({j_r - 1'b1, 12'd0}));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_EXPM: begin
        mul_a = 32'(ord);
        mul_b = 32'(period_r);
      end
      ST_MISS: begin
        mul_a = $signed(m_r);
        mul_b = $signed(vofd_pkg::EXP_ROM[k_r]);
      end
      ST_SMUL: begin
        mul_a = samp;
        mul_b = $signed(m_r);
      end
      ST_WMUL: begin
        mul_a = w_r;
        mul_b = 32'(num);
      end
      ST_TXM: begin
        mul_a = w_r;
        mul_b = hist_rd;
      end
      ST_T0M: begin
        mul_a = w_r;
        mul_b = x0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  vofd_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // product term in Q16, floor
  assign tsh = AW'(prod_r >>> 20);

  // sample scaled by the period power, saturated to +-(2^47-1)
  always_comb begin
    logic signed [13:0] negsh;
    logic [5:0]         amt;
    logic signed [63:0] v;
    logic signed [63:0] lim;
    negsh = -sh_r;
    amt   = (negsh > 14'sd63) ? 6'd63 : negsh[5:0];
    dval  = '0;
    v     = '0;
    lim   = '0;
    if (sh_r < 14'sd0) begin
      v = prod_r >>> amt;
      if (v > vofd_pkg::DMAX64) begin
        dval = vofd_pkg::DMAX48;
      end else if (v < -vofd_pkg::DMAX64) begin
        dval = -vofd_pkg::DMAX48;
      end else begin
        dval = v[47:0];
      end
    end else if (prod_r == '0) begin
      dval = '0;
    end else if (sh_r >= 14'sd17) begin
      dval = prod_r[63] ? -vofd_pkg::DMAX48 : vofd_pkg::DMAX48;
    end else begin
      if (prod_r > vofd_pkg::DMAX64) begin
        v = vofd_pkg::DMAX64;
      end else if (prod_r < -vofd_pkg::DMAX64) begin
        v = -vofd_pkg::DMAX64;
      end else begin
        v = prod_r;
      end
      lim = vofd_pkg::DMAX64 >>> sh_r[4:0];
      if (v > lim) begin
        dval = vofd_pkg::DMAX48;
      end else if (v < -lim) begin
        dval = -vofd_pkg::DMAX48;
      end else begin
        dval = 48'(v <<< sh_r[4:0]);
      end
    end
  end

  // divider hookup: |w*num| / 2^12 divided by j
  assign pabs             = prod_r[63] ? -prod_r : prod_r;
  assign div_req.start    = (state_r == ST_WLD);
  assign div_req.dividend = pabs[12 +: vofd_pkg::DIVD_W];
  assign div_req.divisor  = j_r;

  vofd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // new weight, truncated toward zero and saturated
  always_comb begin
    logic [30:0] wm;
    wm = (|div_rsp.quot[vofd_pkg::DIVP_W-1:31]) ? 31'h7FFF_FFFF : div_rsp.quot[30:0];
    w_div = neg_r ? -$signed({1'b0, wm}) : $signed({1'b0, wm});
  end

  // channel result, saturated to 32 bits
  always_comb begin
    logic signed [AW:0] sum;
    sum = {d_r[AW-1], d_r} + {cor_r[AW-1], cor_r};
    if ((sum[AW:31] == '0) || (sum[AW:31] == '1)) begin
      res_val = sum[31:0];
    end else begin
      res_val = sum[AW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // per-channel history memories
  for (genvar c = 0; c < vofd_pkg::CHANNELS; c++) begin : g_hist
    logic          we;
    logic [HW-1:0] waddr;
    logic [SW-1:0] wdata;

    assign we    = fill_act ? fill_pend_r[c]
                            : ((state_r == ST_RES) && (ch_r == vofd_pkg::CH_W'(c)));
    assign waddr = fill_act ? fill_cnt_r : pos_r;
    assign wdata = fill_act ? init_r[c] : res_val;

    vofd_ram #(
      .WIDTH (SW),
      .DEPTH (vofd_pkg::HISTORY)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (idx_r),
      .rdata (ram_rd[c])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      hlen_r   <= vofd_pkg::HLEN_W'(256);
      for (int c = 0; c < vofd_pkg::CHANNELS; c++) begin
        init_r[c] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == vofd_pkg::CFG_IDX_W'(vofd_pkg::REG_LOG2_PERIOD)) begin
        period_r <= $signed(cfg_wdata[vofd_pkg::PERIOD_W-1:0]);
      end
      if (cfg_index == vofd_pkg::CFG_IDX_W'(vofd_pkg::REG_HIST_LEN)) begin
        hlen_r <= cfg_wdata[vofd_pkg::HLEN_W-1:0];
      end
      for (int c = 0; c < vofd_pkg::CHANNELS; c++) begin
        if (cfg_index == vofd_pkg::CFG_IDX_W'(vofd_pkg::REG_INIT_BASE + c)) begin
          init_r[c] <= $signed(cfg_wdata);
        end
      end
    end
  end

  // history fill pass, restarted by an initial value write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_pend_r <= '1;
      fill_cnt_r  <= '0;
    end else if (|init_sel) begin
      fill_pend_r <= fill_pend_r | init_sel;
      fill_cnt_r  <= '0;
    end else if (fill_act) begin
      if (fill_cnt_r == HW'(vofd_pkg::HISTORY - 1)) begin
        fill_pend_r <= '0;
        fill_cnt_r  <= '0;
      end else begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
      end
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // result beat handshake
      if ((state_r == ST_DONE) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            item_r  <= in_tdata;
            ch_r    <= '0;
            if (LW'(pos_r) >= len) begin
              pos_r <= '0;
            end
            state_r <= ST_EXPM;
          end
        end
        ST_EXPM: begin
          state_r <= ST_EXPE;
        end
        ST_EXPE: begin
          // e = floor(-(q*L) / 2^12), split into integer and fraction
          logic signed [63:0] ng;
          ng = -prod_r;
          sh_r    <= 14'($signed(ng[40:28])) - 14'sd30;
          f_r     <= ng[27:12];
          m_r     <= 32'h4000_0000;
          k_r     <= '0;
          state_r <= ST_MISS;
        end
        ST_MISS: begin
          state_r <= ST_MTAK;
        end
        ST_MTAK: begin
          if (f_r[15]) begin
            m_r <= prod_r[61:30];
          end
          f_r <= {f_r[14:0], 1'b0};
          if (k_r == 4'd15) begin
            state_r <= ST_SMUL;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_MISS;
          end
        end
        ST_SMUL: begin
          state_r <= ST_SCAL;
        end
        ST_SCAL: begin
          d_r   <= AW'(dval);
          cor_r <= AW'(x0);
          w_r   <= vofd_pkg::W_ONE;
          j_r   <= HW'(1);
          idx_r <= (pos_r == '0) ? HW'(len - 1'b1) : pos_r - 1'b1;
          state_r <= ST_WMUL;
        end
        ST_WMUL: begin
          state_r <= ST_WLD;
        end
        ST_WLD: begin
          neg_r   <= prod_r[63];
          state_r <= ST_WDIV;
        end
        ST_WDIV: begin
          if (div_rsp.done) begin
            w_r     <= w_div;
            state_r <= ST_TXM;
          end
        end
        ST_TXM: begin
          state_r <= ST_T0M;
        end
        ST_T0M: begin
          d_r     <= j_r[0] ? d_r + tsh : d_r - tsh;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          cor_r <= j_r[0] ? cor_r - tsh : cor_r + tsh;
          if (LW'(j_r) == len - 1'b1) begin
            state_r <= ST_RES;
          end else begin
            j_r     <= j_r + 1'b1;
            idx_r   <= (idx_r == '0) ? HW'(len - 1'b1) : idx_r - 1'b1;
            state_r <= ST_WMUL;
          end
        end
        ST_RES: begin
          res_r[ch_r*SW +: SW] <= res_val;
          if (ch_r == vofd_pkg::CH_W'(vofd_pkg::CHANNELS - 1)) begin
            state_r <= ST_DONE;
          end else begin
            ch_r    <= ch_r + 1'b1;
            state_r <= ST_EXPM;
          end
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            logic [LW-1:0] p1;
            p1 = LW'(pos_r) + 1'b1;
            out_tdata_r  <= res_r;
            pos_r        <= (p1 >= len) ? '0 : p1[HW-1:0];
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE) && !fill_act;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### rtl/vofd_chk.sv
module vofd_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [vofd_pkg::OUT_W-1:0]     out_tdata,
  input logic                           cfg_we,
  input logic [vofd_pkg::CFG_IDX_W-1:0] cfg_index
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // one step at a time: no accept right after an accept
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a step is in progress");

  // history fill follows reset
  a_reset_fill: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready before history fill");

  // an initial value write starts a refill
  a_init_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index >= vofd_pkg::CFG_IDX_W'(vofd_pkg::REG_INIT_BASE))
      && (cfg_index < vofd_pkg::CFG_IDX_W'(vofd_pkg::REG_INIT_BASE + vofd_pkg::CHANNELS))
    |=> !in_tready)
    else $error("input ready during history refill");

endmodule

bind variable_order_fractional_difference vofd_chk u_vofd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import vofd_pkg::*;

  localparam int  STEP_GOAL   = 1650;
  localparam int  CYCLE_LIMIT = 6_000_000;
  localparam int  SETTLE      = 40;
  localparam longint SCALE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint WEIGHT_MAX = 64'sh0000_0000_7FFF_FFFF;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp [CHANNELS];
    logic signed [ORDER_W-1:0]  ord [CHANNELS];
  } step_t;

  typedef logic [OUT_W-1:0] values_t;

  // one row of the directed table: an optional register write, an optional step
  typedef struct {
    bit                   wr;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    bit                   has_step;
    step_t                st;
    bit                   typed;
    values_t              want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  variable_order_fractional_difference uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  longint unsigned pow_table [17];
  logic signed [PERIOD_W-1:0] period_log2;
  logic [HLEN_W-1:0] hist_len;
  int init_val [CHANNELS];
  int past [CHANNELS][HISTORY];
  int wr_pos;

  values_t pending_values [$];
  row_t    directed [$];
  int      mismatches = 0;
  int      steps_sent = 0;
  longint  cycles = 0;
  bit      calm = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // sample times 2^(-q*L), Q16, saturated
  function automatic longint scale_by_period(longint s, longint q);
    longint e, n, p, sh, lim, prd;
    longint unsigned m;
    logic [15:0] f;
    prd = period_log2;
    e = (-(q * prd)) >>> 12;
    n = e >>> 16;
    f = e[15:0];
    m = 64'd1 << 30;
    for (int k = 1; k <= 16; k++)
      if (f[16-k]) m = (m * pow_table[k]) >> 30;
    p = s * longint'(m);
    sh = n - 30;
    if (sh < 0) return clamp_sym(p >>> ((sh < -63) ? 63 : -sh), SCALE_MAX);
    if (p == 0) return 0;
    if (sh >= 17) return (p > 0) ? SCALE_MAX : -SCALE_MAX;
    p = clamp_sym(p, SCALE_MAX);
    lim = SCALE_MAX >>> sh;
    if (p > lim) return SCALE_MAX;
    if (p < -lim) return -SCALE_MAX;
    return p <<< sh;
  endfunction

  function automatic void refill(int c);
    for (int i = 0; i < HISTORY; i++) past[c][i] = init_val[c];
  endfunction

  function automatic void model_write(int idx, logic [CFG_W-1:0] val);
    if (idx == REG_LOG2_PERIOD) period_log2 = val[PERIOD_W-1:0];
    else if (idx == REG_HIST_LEN) hist_len = val[HLEN_W-1:0];
    else if (idx >= REG_INIT_BASE && idx < REG_INIT_BASE + CHANNELS) begin
      init_val[idx - REG_INIT_BASE] = int'(val);
      refill(idx - REG_INIT_BASE);
    end
  endfunction

  // one time step of the difference equation, all channels
  function automatic values_t advance_step(step_t st);
    values_t res;
    int len, pos, idx;
    longint s, q, x0, d, cor, w, num, x, r;
    len = hist_len;
    if (len < 2) len = 2;
    if (len > HISTORY) len = HISTORY;
    if (wr_pos >= len) wr_pos = 0;
    pos = wr_pos;
    for (int c = 0; c < CHANNELS; c++) begin
      s = st.smp[c];
      q = st.ord[c];
      x0 = init_val[c];
      d = scale_by_period(s, q);
      cor = x0;
      w = longint'(1) << 20;
      for (int j = 1; j < len; j++) begin
        num = -q - longint'(j - 1) * 4096;
        idx = (pos >= j) ? pos - j : pos + len - j;
        x = past[c][idx];
        w = clamp_sym((w * num) / (longint'(j) * 4096), WEIGHT_MAX);
        if (j % 2 == 1) begin
          d = d + ((w * x) >>> 20);
          cor = cor - ((w * x0) >>> 20);
        end else begin
          d = d - ((w * x) >>> 20);
          cor = cor + ((w * x0) >>> 20);
        end
      end
      r = d + cor;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      past[c][pos] = int'(r);
      res[SAMPLE_W*c +: SAMPLE_W] = r[31:0];
    end
    wr_pos = pos + 1;
    if (wr_pos >= len) wr_pos = 0;
    return res;
  endfunction

  // result side: random stalls, compare against the oldest expectation
  always @(posedge clk) begin
    values_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_values.size() == 0) begin
        $display("%0t unexpected beat: got %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_values.pop_front();
        for (int c = 0; c < CHANNELS; c++)
          if (out_tdata[SAMPLE_W*c +: SAMPLE_W] !== want[SAMPLE_W*c +: SAMPLE_W]) begin
            $display("%0t out_%0d mismatch: expected %h got %h", $time, c,
                     want[SAMPLE_W*c +: SAMPLE_W], out_tdata[SAMPLE_W*c +: SAMPLE_W]);
            mismatches++;
          end
      end
    end
    out_tready <= rst_n && (calm || $urandom_range(99) >= 8);
  end

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one register write, then cfg_we is held low again before the task returns
  task automatic write_reg(int idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_write(idx, val);
    @(posedge clk);
  endtask

  // send one step; the expectation is either typed or predicted
  task automatic send_step(step_t st, bit typed, values_t want);
    values_t got;
    logic [IN_W-1:0] beat;
    if (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    beat = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      beat[SAMPLE_W*c +: SAMPLE_W] = st.smp[c];
      beat[CHANNELS*SAMPLE_W + ORDER_W*c +: ORDER_W] = st.ord[c];
    end
    in_tvalid <= 1'b1;
    in_tdata <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = advance_step(st);
    pending_values.push_back(typed ? want : got);
    steps_sent++;
  endtask

  function automatic step_t make_step(int s0, int s1, int s2, int s3,
                                      int q0, int q1, int q2, int q3);
    step_t st;
    st.smp[0] = s0; st.smp[1] = s1; st.smp[2] = s2; st.smp[3] = s3;
    st.ord[0] = q0[15:0]; st.ord[1] = q1[15:0]; st.ord[2] = q2[15:0]; st.ord[3] = q3[15:0];
    return st;
  endfunction

  function automatic void row_reg(int idx, logic [CFG_W-1:0] val);
    row_t r;
    r = '{default: '0};
    r.wr = 1'b1;
    r.idx = idx[CFG_IDX_W-1:0];
    r.val = val;
    directed.push_back(r);
  endfunction

  function automatic void row_step(step_t st, bit typed, values_t want);
    row_t r;
    r = '{default: '0};
    r.has_step = 1'b1;
    r.st = st;
    r.typed = typed;
    r.want = want;
    directed.push_back(r);
  endfunction

  function automatic step_t random_step();
    step_t st;
    for (int c = 0; c < CHANNELS; c++) begin
      if ($urandom_range(1)) st.smp[c] = $urandom;
      else st.smp[c] = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      if ($urandom_range(3) == 0) st.ord[c] = 16'($urandom);
      else st.ord[c] = 16'(int'($urandom_range(0, 16384)) - 8192);
    end
    return st;
  endfunction

  initial begin
    step_t st;
    int n_steps, pick, lenv;

    // power table, 2^(2^-k) in Q30
    pow_table[1] = int_sqrt(64'd1 << 61);
    for (int k = 2; k <= 16; k++) pow_table[k] = int_sqrt(pow_table[k-1] << 30);
    period_log2 = '0;
    hist_len = 9'd256;
    wr_pos = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      init_val[c] = 0;
      refill(c);
    end

    // directed table: zero order at zero period passes the sample straight through
    row_step(make_step(32'h7FFF_FFFF, 32'h8000_0000, 0, -1, 0, 0, 0, 0), 1,
             {32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    row_step(make_step(-1, 32'h7FFF_FFFF, 32'h8000_0000, 65536, 0, 0, 0, 0), 1,
             {32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
    row_step(make_step(65536, -65536, 32'h7FFF_FFFF, 32'h8000_0000,
                       -32768, 32767, 4096, -4096), 0, '0);
    row_reg(REG_HIST_LEN, 4);
    row_step(make_step(65536, 65536, 65536, 65536, 2048, 4096, 8192, -2048), 0, '0);
    row_step(make_step(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32767, -32768, -32768, 32767), 0, '0);
    // huge and tiny period powers
    row_reg(REG_LOG2_PERIOD, 32'h007F_FFFF);
    row_step(make_step(65536, -65536, 1, -1, 4096, -4096, 32767, -32768), 0, '0);
    row_step(make_step(32'h7FFF_FFFF, 32'h8000_0000, 0, 12345, -1, 1, 100, -100), 0, '0);
    row_reg(REG_LOG2_PERIOD, 32'h0080_0000);
    row_step(make_step(65536, -65536, 1, -1, 4096, -4096, 32767, -32768), 0, '0);
    // initial value extremes refill the histories
    row_reg(REG_LOG2_PERIOD, 0);
    row_reg(REG_INIT_BASE + 0, 32'h7FFF_FFFF);
    row_reg(REG_INIT_BASE + 1, 32'h8000_0000);
    row_reg(REG_INIT_BASE + 2, 1);
    row_reg(REG_INIT_BASE + 3, 32'hFFFF_FFFF);
    row_step(make_step(0, 0, 0, 0, 0, 0, 0, 0), 1,
             {32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF});
    row_step(make_step(65536, -65536, 32'h7FFF_FFFF, 32'h8000_0000,
                       6144, -6144, 4096, 2048), 0, '0);
    // length extremes and out-of-range lengths
    row_reg(REG_HIST_LEN, 2);
    row_step(make_step(65536, 2, -3, 4, 4096, 2048, -2048, 32767), 0, '0);
    row_reg(REG_HIST_LEN, 1);
    row_step(make_step(7, -7, 65536, -65536, -32768, 32767, 100, 4096), 0, '0);
    row_reg(REG_HIST_LEN, 0);
    row_step(make_step(9, 8, 7, 6, 1024, 512, 256, 128), 0, '0);
    row_reg(REG_HIST_LEN, 511);
    row_step(make_step(65536, 131072, -65536, 5, 2048, 6144, 4096, -1024), 0, '0);
    row_reg(REG_HIST_LEN, 3);
    row_step(make_step(1, 2, 3, 4, 2048, 2048, 2048, 2048), 0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    foreach (directed[i]) begin
      if (directed[i].wr) begin
        settle();
        write_reg(directed[i].idx, directed[i].val);
      end
      if (directed[i].has_step) send_step(directed[i].st, directed[i].typed,
                                          directed[i].want);
    end

    // random phases, each of which may rewrite the period, length and initial values
    for (int phase = 0; steps_sent < STEP_GOAL; phase++) begin
      settle();
      calm = (phase % 10 == 4);
      if ($urandom_range(1)) begin
        pick = $urandom_range(5);
        if (pick == 0) write_reg(REG_LOG2_PERIOD, 32'h007F_FFFF);
        else if (pick == 1) write_reg(REG_LOG2_PERIOD, 32'h0080_0000);
        else if (pick == 2) write_reg(REG_LOG2_PERIOD, $urandom);
        else write_reg(REG_LOG2_PERIOD, int'($urandom_range(0, 1 << 19)) - (1 << 18));
      end
      n_steps = $urandom_range(15, 45);
      if (phase % 15 == 7) begin
        // long histories are slow, keep these phases short
        pick = $urandom_range(2);
        lenv = (pick == 0) ? 256 : (pick == 1) ? 511 : $urandom_range(257, 510);
        n_steps = 3;
      end else begin
        pick = $urandom_range(19);
        if (pick == 0) lenv = $urandom_range(1);
        else if (pick == 1) lenv = $urandom_range(9, 16);
        else lenv = $urandom_range(2, 8);
      end
      if ($urandom_range(3) != 0) write_reg(REG_HIST_LEN, lenv);
      else if (lenv > 16) write_reg(REG_HIST_LEN, lenv);
      for (int c = 0; c < CHANNELS; c++)
        if ($urandom_range(3) == 0) begin
          if ($urandom_range(1)) write_reg(REG_INIT_BASE + c, $urandom);
          else write_reg(REG_INIT_BASE + c, int'($urandom_range(0, 1 << 18)) - (1 << 17));
        end
      for (int i = 0; i < n_steps; i++) begin
        st = random_step();
        send_step(st, 0, '0);
      end
    end

    settle();
    calm = 1'b0;
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/vofd_pkg.sv
rtl/vofd_ram.sv
rtl/vofd_mul.sv
rtl/vofd_div.sv
rtl/variable_order_fractional_difference.sv
rtl/vofd_chk.sv
tb/sv/testbench.sv
